// File: hw/rtl/srrmf_pkg.sv
// Shared types and constants for the read-holding-registers request framer.
// No dependencies; every other file in hw/rtl imports this package.
package srrmf_pkg;

  // Largest register count a request may ask for.
  localparam int MAX_QUANTITY = 16;

  localparam int FUNC_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int ADDR_W   = 16;
  localparam int COUNT_W  = 7;
  localparam int KIND_W   = 2;
  localparam int INDEX_W  = 4;
  localparam int VALUE_W  = 16;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int REG_DEPTH = 16;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  READ_FUNC = 8'h03;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SEND = 2'd0,
    FUNC_BYTE = 2'd1,
    FUNC_FAIL = 2'd2
  } func_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_TX     = 2'd0,
    KIND_REG    = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_BAD_COUNT   = 3'd1,
    ST_RX_FAILED   = 3'd2,
    ST_CRC_ERROR   = 3'd3,
    ST_HDR_MISMATCH = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLAVE_ADDR = 2'd0,
    CFG_START_ADDR = 2'd1,
    CFG_REG_COUNT  = 2'd2
  } cfg_idx_t;

  // One bit of the reflected CRC-16; the data bit enters at the low end.
  function automatic logic [15:0] crc_bit(input logic [15:0] crc, input logic din);
    logic fb;
    fb = crc[0] ^ din;
    return fb ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
  endfunction

endpackage

// File: hw/rtl/srrmf_if.sv
// Valid/ready channel interfaces for the request framer: input items,
// result items and configuration writes. Depends on srrmf_pkg.
interface srrmf_item_if import srrmf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface srrmf_result_if import srrmf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [BYTE_W-1:0]   tx_byte;
  logic [INDEX_W-1:0]  reg_index;
  logic [VALUE_W-1:0]  reg_value;
  logic [STATUS_W-1:0] status;
  logic                last;

  modport source (output valid, output kind, output tx_byte, output reg_index,
                  output reg_value, output status, output last, input ready);
  modport sink   (input valid, input kind, input tx_byte, input reg_index,
                  input reg_value, input status, input last, output ready);
endinterface

interface srrmf_cfg_if import srrmf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/serial_read_registers_master_frame.sv
// Top level of the read-holding-registers request framer and reply checker.
// Depends on srrmf_pkg and the channel interfaces in srrmf_if.sv.

// The block takes one input transaction at a time and is ready again only
// when every result it caused has been handed to the result register. A send
// transaction shifts each of the six header bytes through a bit-serial CRC
// and emits each byte after its CRC step, then emits the two CRC bytes; a
// bad register count gives one status transaction instead. A reply byte runs
// through the same one-bit CRC step; the byte that completes the reply adds
// one result per register value plus one for the final ok status (or one
// status transaction for a CRC or header failure). Reply bytes and receive
// failures that arrive while no request is outstanding are dropped without
// any result. The result side holds one registered transaction, and
// downstream backpressure holds the emit, drain and status states.

module serial_read_registers_master_frame import srrmf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  srrmf_cfg_if.sink   cfg,
  srrmf_item_if.sink  item,
  srrmf_result_if.source result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TX_CRC,
    S_TX_EMIT,
    S_RX_CRC,
    S_RX_DONE,
    S_DRAIN,
    S_STATUS
  } state_t;

  // Configuration registers.
  logic [BYTE_W-1:0]  slave_address;
  logic [ADDR_W-1:0]  start_address;
  logic [COUNT_W-1:0] register_count;

  // Transaction state.
  state_t             state;
  logic               awaiting;
  logic [7:0]         byte_cnt;
  logic [15:0]        crc;
  logic               header_bad;
  logic [7:0]         held_high;
  logic [7:0]         shift_byte;
  logic [2:0]         bit_cnt;
  logic [2:0]         tx_index;
  logic [COUNT_W-1:0] rd_idx;
  status_t            status_code;
  logic               rx_done;

  // Reply register store, written as each low byte arrives.
  logic [VALUE_W-1:0] regs [REG_DEPTH];

  // Result register.
  logic                r_valid;
  kind_t               r_kind;
  logic [BYTE_W-1:0]   r_tx_byte;
  logic [INDEX_W-1:0]  r_index;
  logic [VALUE_W-1:0]  r_value;
  status_t             r_status;
  logic                r_last;

  logic               out_free;
  logic               load_result;
  logic               count_valid;
  logic [8:0]         expected;
  logic [7:0]         byte_cnt_next;
  logic               reply_done;
  logic [7:0]         pos_m3;
  logic               item_take;
  logic               store_low;
  logic [7:0]         cur_frame_byte;
  logic [7:0]         next_frame_byte;

  // Byte k of the request frame; the CRC bytes come from the live CRC.
  function automatic logic [7:0] frame_byte(input logic [2:0] k,
                                            input logic [7:0] addr,
                                            input logic [15:0] start,
                                            input logic [6:0] count,
                                            input logic [15:0] c);
    logic [7:0] b;
    unique case (k)
      3'd0:    b = addr;
      3'd1:    b = READ_FUNC;
      3'd2:    b = start[15:8];
      3'd3:    b = start[7:0];
      3'd4:    b = 8'h00;
      3'd5:    b = {1'b0, count};
      3'd6:    b = c[7:0];
      default: b = c[15:8];
    endcase
    return b;
  endfunction

  assign cfg.ready  = 1'b1;
  assign item.ready = (state == S_IDLE);
  assign item_take  = item.valid && (state == S_IDLE);
  assign out_free   = !r_valid || result.ready;

  // The result register takes a new transaction in this cycle.
  assign load_result = out_free &&
                       (state == S_TX_EMIT || state == S_DRAIN || state == S_STATUS);

  assign count_valid   = (register_count != '0) &&
                         (register_count <= COUNT_W'(MAX_QUANTITY));
  assign expected      = 9'd5 + {1'b0, register_count, 1'b0};
  assign byte_cnt_next = (byte_cnt == 8'hFF) ? byte_cnt : byte_cnt + 8'd1;
  assign reply_done    = ({1'b0, byte_cnt_next} >= expected);
  assign pos_m3        = byte_cnt - 8'd3;

  assign cur_frame_byte  = frame_byte(tx_index, slave_address, start_address,
                                      register_count, crc);
  assign next_frame_byte = frame_byte(tx_index + 3'd1, slave_address, start_address,
                                      register_count, crc);

  assign result.valid     = r_valid;
  assign result.kind      = r_kind;
  assign result.tx_byte   = r_tx_byte;
  assign result.reg_index = r_index;
  assign result.reg_value = r_value;
  assign result.status    = r_status;
  assign result.last      = r_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address  <= 8'd1;
      start_address  <= '0;
      register_count <= 7'd10;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_SLAVE_ADDR: slave_address  <= cfg.data[BYTE_W-1:0];
        CFG_START_ADDR: start_address  <= cfg.data[ADDR_W-1:0];
        CFG_REG_COUNT:  register_count <= cfg.data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // A reply byte at an even position from 4 on completes one register.
  assign store_low = item_take && (item.func == FUNC_BYTE) && awaiting && count_valid &&
                     (byte_cnt >= 8'd3) && !byte_cnt[0];

  always_ff @(posedge clk) begin
    if (store_low) begin
      regs[pos_m3[4:1]] <= {held_high, item.rx_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      awaiting    <= 1'b0;
      byte_cnt    <= '0;
      crc         <= CRC_INIT;
      header_bad  <= 1'b0;
      held_high   <= '0;
      shift_byte  <= '0;
      bit_cnt     <= '0;
      tx_index    <= '0;
      rd_idx      <= '0;
      status_code <= ST_OK;
      rx_done     <= 1'b0;
      r_valid     <= 1'b0;
      r_kind      <= KIND_TX;
      r_tx_byte   <= '0;
      r_index     <= '0;
      r_value     <= '0;
      r_status    <= ST_OK;
      r_last      <= 1'b0;
    end else begin
      if (r_valid && result.ready && !load_result) begin
        r_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            unique case (item.func)
              FUNC_SEND: begin
                awaiting   <= 1'b0;
                byte_cnt   <= '0;
                crc        <= CRC_INIT;
                header_bad <= 1'b0;
                held_high  <= '0;
                if (!count_valid) begin
                  status_code <= ST_BAD_COUNT;
                  state       <= S_STATUS;
                end else begin
                  tx_index   <= '0;
                  shift_byte <= slave_address;
                  bit_cnt    <= '0;
                  state      <= S_TX_CRC;
                end
              end
              FUNC_BYTE: begin
                if (awaiting) begin
                  if (!count_valid) begin
                    awaiting    <= 1'b0;
                    byte_cnt    <= '0;
                    crc         <= CRC_INIT;
                    header_bad  <= 1'b0;
                    held_high   <= '0;
                    status_code <= ST_BAD_COUNT;
                    state       <= S_STATUS;
                  end else begin
                    if ((byte_cnt == 8'd0 && item.rx_byte != slave_address) ||
                        (byte_cnt == 8'd1 && item.rx_byte != READ_FUNC) ||
                        (byte_cnt == 8'd2 && item.rx_byte != {register_count, 1'b0})) begin
                      header_bad <= 1'b1;
                    end
                    if (byte_cnt >= 8'd3 && byte_cnt[0]) begin
                      held_high <= item.rx_byte;
                    end
                    byte_cnt   <= byte_cnt_next;
                    rx_done    <= reply_done;
                    shift_byte <= item.rx_byte;
                    bit_cnt    <= '0;
                    state      <= S_RX_CRC;
                  end
                end
              end
              FUNC_FAIL: begin
                if (awaiting) begin
                  awaiting    <= 1'b0;
                  byte_cnt    <= '0;
                  crc         <= CRC_INIT;
                  header_bad  <= 1'b0;
                  held_high   <= '0;
                  status_code <= ST_RX_FAILED;
                  state       <= S_STATUS;
                end
              end
              default: ;
            endcase
          end
        end

        S_TX_CRC, S_RX_CRC: begin
          crc        <= crc_bit(crc, shift_byte[0]);
          shift_byte <= shift_byte >> 1;
          bit_cnt    <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) begin
            state <= (state == S_TX_CRC) ? S_TX_EMIT : S_RX_DONE;
          end
        end

        S_TX_EMIT: begin
          if (out_free) begin
            r_valid   <= 1'b1;
            r_kind    <= KIND_TX;
            r_tx_byte <= cur_frame_byte;
            r_index   <= '0;
            r_value   <= '0;
            r_status  <= ST_OK;
            r_last    <= (tx_index == 3'd7);
            tx_index  <= tx_index + 3'd1;
            if (tx_index == 3'd7) begin
              // Frame is out; the CRC now restarts for the reply.
              crc      <= CRC_INIT;
              awaiting <= 1'b1;
              state    <= S_IDLE;
            end else if (tx_index < 3'd5) begin
              shift_byte <= next_frame_byte;
              bit_cnt    <= '0;
              state      <= S_TX_CRC;
            end
          end
        end

        S_RX_DONE: begin
          if (!rx_done) begin
            state <= S_IDLE;
          end else begin
            awaiting   <= 1'b0;
            byte_cnt   <= '0;
            crc        <= CRC_INIT;
            header_bad <= 1'b0;
            held_high  <= '0;
            rd_idx     <= '0;
            if (crc != 16'h0000) begin
              status_code <= ST_CRC_ERROR;
              state       <= S_STATUS;
            end else if (header_bad) begin
              status_code <= ST_HDR_MISMATCH;
              state       <= S_STATUS;
            end else begin
              state <= S_DRAIN;
            end
          end
        end

        S_DRAIN: begin
          if (out_free) begin
            r_valid   <= 1'b1;
            r_kind    <= KIND_REG;
            r_tx_byte <= '0;
            r_index   <= rd_idx[INDEX_W-1:0];
            r_value   <= regs[rd_idx[INDEX_W-1:0]];
            r_status  <= ST_OK;
            r_last    <= 1'b0;
            if (rd_idx == register_count - 7'd1) begin
              status_code <= ST_OK;
              state       <= S_STATUS;
            end else begin
              rd_idx <= rd_idx + 7'd1;
            end
          end
        end

        S_STATUS: begin
          if (out_free) begin
            r_valid   <= 1'b1;
            r_kind    <= KIND_STATUS;
            r_tx_byte <= '0;
            r_index   <= '0;
            r_value   <= '0;
            r_status  <= status_code;
            r_last    <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for serial_read_registers_master_frame: request
// framing, reply checking and status reporting. Depends on srrmf_pkg and the
// channel interfaces in hw/rtl/srrmf_if.sv.
module tb;
  import srrmf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // A value that only exists in the two-bit selector and config index.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED  = 2'd3;

  // Cycles to wait after the last result before touching the registers; a
  // reply byte that causes no result still keeps the CRC shifter busy.
  localparam int SETTLE_CYCLES  = 24;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 1500;
  localparam int RANDOM_ITEMS   = 400;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG, ROW_REPLY} row_op_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_STATUS} check_t;
  typedef enum logic [1:0] {RPL_GOOD, RPL_BAD_CRC, RPL_BAD_HDR} reply_t;

  typedef struct {
    kind_t       kind;
    logic [7:0]  tx;
    logic [3:0]  idx;
    logic [15:0] val;
    status_t     st;
    logic        last;
  } result_t;

  typedef struct {
    row_op_t     op;
    logic [1:0]  func;
    logic [15:0] value;
    logic [1:0]  idx;
    check_t      chk;
    status_t     st;
    reply_t      rmode;
    int          nbytes;
  } row_t;

  logic clk;
  logic rst;

  srrmf_cfg_if    cfg_ch ();
  srrmf_item_if   item_ch ();
  srrmf_result_if res_ch ();

  serial_read_registers_master_frame dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (item_ch),
    .result (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Our own copy of the configuration registers and the reply tracker.
  logic [7:0]  cfg_slave;
  logic [15:0] cfg_start;
  logic [6:0]  cfg_count;
  logic        reply_pending;
  logic [7:0]  reply_bytes;
  logic [15:0] reply_crc;
  logic        header_wrong;
  logic [7:0]  high_byte;
  logic [15:0] reply_words [16];

  result_t awaited_results [$];  // Results still owed by the block, oldest first.
  result_t step_out [$];         // Results of the item just predicted.
  row_t    directed_rows [$];

  int busy_items;   // Items that did something (ignored ones are not counted).
  int mismatches;
  int burst_left;
  bit pace_sender;

  // Reflected CRC-16, one whole byte at a time.
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++)
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic bit count_ok();
    return cfg_count != 7'd0 && cfg_count <= MAX_QUANTITY;
  endfunction

  function automatic void clear_reply();
    reply_pending = 1'b0;
    reply_bytes   = 8'd0;
    reply_crc     = CRC_INIT;
    header_wrong  = 1'b0;
    high_byte     = 8'd0;
  endfunction

  function automatic void add_result(kind_t k, logic [7:0] tx, logic [3:0] idx,
                                     logic [15:0] val, status_t st);
    result_t r;
    r.kind = k;
    r.tx   = tx;
    r.idx  = idx;
    r.val  = val;
    r.st   = st;
    r.last = 1'b0;
    step_out.push_back(r);
  endfunction

  // Works out every result that one accepted item causes and advances the
  // tracker. The results land in step_out with last set on the final one.
  function automatic void predict_frame_step(logic [1:0] f, logic [7:0] b);
    logic [7:0]  frame [8];
    logic [15:0] crc;
    logic [7:0]  pos;
    logic [7:0]  slot;
    result_t     r;
    int          need;
    step_out.delete();
    case (f)
      FUNC_SEND: begin
        busy_items++;
        clear_reply();
        if (!count_ok()) begin
          add_result(KIND_STATUS, 8'h00, 4'h0, 16'h0000, ST_BAD_COUNT);
        end else begin
          frame[0] = cfg_slave;
          frame[1] = READ_FUNC;
          frame[2] = cfg_start[15:8];
          frame[3] = cfg_start[7:0];
          frame[4] = 8'h00;
          frame[5] = {1'b0, cfg_count};
          crc = CRC_INIT;
          for (int i = 0; i < 6; i++)
            crc = crc16_byte(crc, frame[i]);
          frame[6] = crc[7:0];
          frame[7] = crc[15:8];
          for (int i = 0; i < 8; i++)
            add_result(KIND_TX, frame[i], 4'h0, 16'h0000, ST_OK);
          reply_pending = 1'b1;
        end
      end
      FUNC_FAIL: begin
        if (reply_pending) begin
          busy_items++;
          clear_reply();
          add_result(KIND_STATUS, 8'h00, 4'h0, 16'h0000, ST_RX_FAILED);
        end
      end
      FUNC_BYTE: begin
        if (reply_pending) begin
          busy_items++;
          if (!count_ok()) begin
            // The count went bad while we were waiting.
            clear_reply();
            add_result(KIND_STATUS, 8'h00, 4'h0, 16'h0000, ST_BAD_COUNT);
          end else begin
            pos  = reply_bytes;
            need = 5 + 2 * int'(cfg_count);
            reply_crc = crc16_byte(reply_crc, b);
            if (pos == 8'd0 && b != cfg_slave) header_wrong = 1'b1;
            if (pos == 8'd1 && b != READ_FUNC) header_wrong = 1'b1;
            if (pos == 8'd2 && b != {cfg_count, 1'b0}) header_wrong = 1'b1;
            if (pos >= 8'd3) begin
              slot = pos - 8'd3;
              if (!slot[0]) high_byte = b;
              else reply_words[slot[4:1]] = {high_byte, b};
            end
            if (pos < 8'd255) reply_bytes = pos + 8'd1;
            if (int'(reply_bytes) >= need) begin
              if (reply_crc != 16'h0000) begin
                add_result(KIND_STATUS, 8'h00, 4'h0, 16'h0000, ST_CRC_ERROR);
              end else if (header_wrong) begin
                add_result(KIND_STATUS, 8'h00, 4'h0, 16'h0000, ST_HDR_MISMATCH);
              end else begin
                for (int i = 0; i < int'(cfg_count); i++)
                  add_result(KIND_REG, 8'h00, i[3:0], reply_words[i[3:0]], ST_OK);
                add_result(KIND_STATUS, 8'h00, 4'h0, 16'h0000, ST_OK);
              end
              clear_reply();
            end
          end
        end
      end
      default: ;
    endcase
    if (step_out.size() > 0) begin
      r = step_out.pop_back();
      r.last = 1'b1;
      step_out.push_back(r);
    end
  endfunction

  // Waits until every owed result is out and the block has had time to
  // finish any byte that produced nothing. Ends on a falling edge.
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    wait (awaited_results.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_SLAVE_ADDR: cfg_slave = data[7:0];
      CFG_START_ADDR: cfg_start = data;
      CFG_REG_COUNT:  cfg_count = data[6:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Presents one input item and predicts its results at the accepting edge.
  // When pacing is on, the sender runs in bursts, with valid dropped in the gaps.
  task automatic put_item(input logic [1:0] f, input logic [7:0] b,
                          input check_t chk, input status_t st);
    result_t r;
    int      gap;
    if (pace_sender) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 12);
        item_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
    end
    item_ch.valid   <= 1'b1;
    item_ch.func    <= f;
    item_ch.rx_byte <= b;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    predict_frame_step(f, b);
    case (chk)
      CHK_MODEL: begin
        foreach (step_out[i]) awaited_results.push_back(step_out[i]);
      end
      CHK_STATUS: begin
        r.kind = KIND_STATUS;
        r.tx   = 8'h00;
        r.idx  = 4'h0;
        r.val  = 16'h0000;
        r.st   = st;
        r.last = 1'b1;
        awaited_results.push_back(r);
      end
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Builds a reply for the current settings and feeds up to limit bytes of
  // it (zero means all). A bad header keeps a matching CRC so that only the
  // header check trips; a bad CRC corrupts one byte after the CRC is added.
  task automatic send_reply(input reply_t mode, input bit fixed, input logic [15:0] fill,
                            input int limit);
    logic [7:0]  frame_q [$];
    logic [15:0] crc;
    logic [15:0] word;
    logic [7:0]  flip;
    int          pos;
    int          n;
    frame_q.push_back(cfg_slave);
    frame_q.push_back(READ_FUNC);
    frame_q.push_back({cfg_count, 1'b0});
    for (int i = 0; i < int'(cfg_count); i++) begin
      word = fixed ? fill : 16'($urandom);
      frame_q.push_back(word[15:8]);
      frame_q.push_back(word[7:0]);
    end
    if (mode == RPL_BAD_HDR) begin
      pos  = $urandom_range(0, 2);
      flip = 8'($urandom_range(1, 255));
      frame_q[pos] = frame_q[pos] ^ flip;
    end
    crc = CRC_INIT;
    foreach (frame_q[i]) crc = crc16_byte(crc, frame_q[i]);
    frame_q.push_back(crc[7:0]);
    frame_q.push_back(crc[15:8]);
    if (mode == RPL_BAD_CRC) begin
      pos  = $urandom_range(0, frame_q.size() - 1);
      flip = 8'($urandom_range(1, 255));
      frame_q[pos] = frame_q[pos] ^ flip;
    end
    n = (limit == 0 || limit > frame_q.size()) ? frame_q.size() : limit;
    for (int i = 0; i < n; i++)
      put_item(FUNC_BYTE, frame_q[i], CHK_MODEL, ST_OK);
  endtask

  // Anything at all: idle bytes, failures, the unused selector, sends, and
  // bytes that break a reply in progress.
  task automatic send_noise(input int n);
    logic [1:0] f;
    logic [7:0] b;
    repeat (n) begin
      f = 2'($urandom_range(0, 3));
      b = 8'($urandom_range(0, 255));
      put_item(f, b, CHK_MODEL, ST_OK);
    end
  endtask

  function automatic void row_item(logic [1:0] f, logic [7:0] b, check_t chk, status_t st);
    row_t r;
    r.op = ROW_ITEM; r.func = f; r.value = {8'h00, b}; r.idx = CFG_UNUSED;
    r.chk = chk; r.st = st; r.rmode = RPL_GOOD; r.nbytes = 0;
    directed_rows.push_back(r);
  endfunction

  function automatic void row_cfg(logic [1:0] idx, logic [15:0] data);
    row_t r;
    r.op = ROW_CFG; r.func = FUNC_UNUSED; r.value = data; r.idx = idx;
    r.chk = CHK_MODEL; r.st = ST_OK; r.rmode = RPL_GOOD; r.nbytes = 0;
    directed_rows.push_back(r);
  endfunction

  function automatic void row_reply(reply_t mode, logic [15:0] fill, int nbytes);
    row_t r;
    r.op = ROW_REPLY; r.func = FUNC_BYTE; r.value = fill; r.idx = CFG_UNUSED;
    r.chk = CHK_MODEL; r.st = ST_OK; r.rmode = mode; r.nbytes = nbytes;
    directed_rows.push_back(r);
  endfunction

  function automatic void report_mismatch(string detail);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", detail);
  endfunction

  // The receiver picks a stall pattern, keeps it for a while, then moves on:
  // always ready, a fixed duty cycle, or random draws ready three times in four.
  initial begin : result_sink
    int mode;
    int hold;
    int period;
    int stall;
    int tick;
    res_ch.ready = 1'b0;
    mode = 0;
    hold = 0;
    period = 2;
    stall = 1;
    tick = 0;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        mode   = $urandom_range(0, 2);
        hold   = $urandom_range(40, 300);
        period = $urandom_range(2, 8);
        stall  = $urandom_range(1, period - 1);
      end
      hold--;
      tick++;
      case (mode)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= (tick % period) >= stall;
        default: res_ch.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Every result transaction is matched against the oldest owed result.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf(
          "unexpected result kind=%0d tx=%02h idx=%0d val=%04h st=%0d last=%0d",
          res_ch.kind, res_ch.tx_byte, res_ch.reg_index,
          res_ch.reg_value, res_ch.status, res_ch.last));
      end else begin
        want = awaited_results.pop_front();
        if (res_ch.kind !== want.kind || res_ch.tx_byte !== want.tx ||
            res_ch.reg_index !== want.idx || res_ch.reg_value !== want.val ||
            res_ch.status !== want.st || res_ch.last !== want.last)
          report_mismatch({
            $sformatf("expected kind=%0d tx=%02h idx=%0d val=%04h st=%0d last=%0d",
                      want.kind, want.tx, want.idx, want.val, want.st, want.last),
            $sformatf(", got kind=%0d tx=%02h idx=%0d val=%04h st=%0d last=%0d",
                      res_ch.kind, res_ch.tx_byte, res_ch.reg_index,
                      res_ch.reg_value, res_ch.status, res_ch.last)});
      end
    end
  end

  // A hang shows up as a long stretch with no transaction on any channel.
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    row_t        row;
    int          target;
    int          roll;
    int          cnt;
    logic [2:0]  writes;
    logic [15:0] word;
    logic [7:0]  b;

    // Every input is known from time zero; reset state of our copy follows
    // the block's reset values.
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.func = FUNC_SEND;
    item_ch.rx_byte = 8'h00;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_SLAVE_ADDR;
    cfg_ch.data = 16'h0000;
    cfg_slave = 8'd1;
    cfg_start = 16'd0;
    cfg_count = 7'd10;
    clear_reply();
    foreach (reply_words[i]) reply_words[i] = 16'h0000;
    busy_items = 0;
    mismatches = 0;
    burst_left = 0;
    pace_sender = 1'b1;

    // Directed rows. Status rows carry their expected code; everything else
    // is checked through the predictor.
    // Nothing outstanding after reset: bytes, failures and the unused
    // selector must all be dropped silently.
    row_item(FUNC_BYTE, 8'hA5, CHK_NONE, ST_OK);
    row_item(FUNC_FAIL, 8'h5A, CHK_NONE, ST_OK);
    row_item(FUNC_UNUSED, 8'hFF, CHK_NONE, ST_OK);
    // Request with reset settings, then abandon it with a receive failure.
    row_item(FUNC_SEND, 8'h00, CHK_MODEL, ST_OK);
    row_item(FUNC_FAIL, 8'h00, CHK_STATUS, ST_RX_FAILED);
    // Zero and the largest encodable count are both rejected at send time.
    row_cfg(CFG_REG_COUNT, 16'd0);
    row_item(FUNC_SEND, 8'h00, CHK_STATUS, ST_BAD_COUNT);
    row_cfg(CFG_REG_COUNT, 16'd127);
    row_item(FUNC_SEND, 8'hFF, CHK_STATUS, ST_BAD_COUNT);
    // All-ones addresses and a full good reply of one register.
    row_cfg(CFG_SLAVE_ADDR, 16'h00FF);
    row_cfg(CFG_START_ADDR, 16'hFFFF);
    row_cfg(CFG_REG_COUNT, 16'd1);
    row_item(FUNC_SEND, 8'h00, CHK_MODEL, ST_OK);
    row_reply(RPL_GOOD, 16'hFFFF, 0);
    // All-zero addresses; a second send while the first is pending restarts.
    row_cfg(CFG_SLAVE_ADDR, 16'h0000);
    row_cfg(CFG_START_ADDR, 16'h0000);
    row_item(FUNC_SEND, 8'h00, CHK_MODEL, ST_OK);
    row_item(FUNC_SEND, 8'h00, CHK_MODEL, ST_OK);
    // Count made invalid mid-reply: the next byte ends the wait.
    row_reply(RPL_GOOD, 16'h0000, 3);
    row_cfg(CFG_REG_COUNT, 16'd0);
    row_item(FUNC_BYTE, 8'h00, CHK_STATUS, ST_BAD_COUNT);
    // Count lowered mid-reply below the bytes already taken: the next byte
    // overshoots the new length and completes the reply.
    row_cfg(CFG_REG_COUNT, 16'd16);
    row_item(FUNC_SEND, 8'h00, CHK_MODEL, ST_OK);
    row_reply(RPL_GOOD, 16'h8001, 7);
    row_cfg(CFG_REG_COUNT, 16'd1);
    row_item(FUNC_BYTE, 8'h00, CHK_MODEL, ST_OK);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.op)
        ROW_CFG:   cfg_write(row.idx, row.value);
        ROW_ITEM:  put_item(row.func, row.value[7:0], row.chk, row.st);
        default:   send_reply(row.rmode, 1'b1, row.value, row.nbytes);
      endcase
    end

    // Random phases. Most are complete request/reply exchanges with random
    // data, so the register assembly and the ok path get exercised; the
    // rest corrupt, truncate, restart or scramble the exchange.
    target = busy_items + RANDOM_ITEMS;
    while (busy_items < target) begin
      pace_sender = ($urandom_range(0, 4) != 0);

      if (!count_ok() || $urandom_range(0, 9) < 3) begin
        writes = 3'($urandom_range(1, 7));
        if (writes[0]) begin
          word = 16'($urandom_range(0, 255));
          cfg_write(CFG_SLAVE_ADDR, word);
        end
        if (writes[1]) begin
          word = 16'($urandom);
          cfg_write(CFG_START_ADDR, word);
        end
        if (writes[2] || !count_ok()) begin
          // Mostly short replies; now and then the largest, rarely a bad one.
          roll = $urandom_range(0, 99);
          if (roll < 65) cnt = $urandom_range(1, 4);
          else if (roll < 85) cnt = $urandom_range(5, MAX_QUANTITY - 1);
          else if (roll < 95) cnt = MAX_QUANTITY;
          else if (roll < 97) cnt = 0;
          else cnt = $urandom_range(MAX_QUANTITY + 1, 127);
          cfg_write(CFG_REG_COUNT, cnt[15:0]);
        end
        if ($urandom_range(0, 19) == 0) begin
          word = 16'($urandom);
          cfg_write(CFG_UNUSED, word);
        end
      end

      cnt  = int'(cfg_count);
      roll = $urandom_range(0, 99);
      b    = 8'($urandom_range(0, 255));
      if (!count_ok()) begin
        put_item(FUNC_SEND, b, CHK_MODEL, ST_OK);
        send_noise($urandom_range(1, 4));
      end else if (roll < 60) begin
        put_item(FUNC_SEND, b, CHK_MODEL, ST_OK);
        send_reply(RPL_GOOD, 1'b0, 16'h0000, 0);
      end else if (roll < 70) begin
        put_item(FUNC_SEND, b, CHK_MODEL, ST_OK);
        send_reply(RPL_BAD_CRC, 1'b0, 16'h0000, 0);
      end else if (roll < 78) begin
        put_item(FUNC_SEND, b, CHK_MODEL, ST_OK);
        send_reply(RPL_BAD_HDR, 1'b0, 16'h0000, 0);
      end else if (roll < 86) begin
        put_item(FUNC_SEND, b, CHK_MODEL, ST_OK);
        send_reply(RPL_GOOD, 1'b0, 16'h0000, $urandom_range(1, 4 + 2 * cnt));
        put_item(FUNC_FAIL, b, CHK_MODEL, ST_OK);
      end else if (roll < 92) begin
        // Leave the reply unfinished; the next phase restarts or reconfigures.
        put_item(FUNC_SEND, b, CHK_MODEL, ST_OK);
        send_reply(RPL_GOOD, 1'b0, 16'h0000, $urandom_range(1, 4 + 2 * cnt));
      end else begin
        send_noise($urandom_range(2, 8));
      end
    end

    // Drain: everything owed must arrive, then a quiet tail catches extras.
    item_ch.valid <= 1'b0;
    wait (awaited_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: serial_read_registers_master_frame.f
hw/rtl/srrmf_pkg.sv
hw/rtl/srrmf_if.sv
hw/rtl/serial_read_registers_master_frame.sv
tb/sv/tb.sv
